// ----- rtl/m4vt_pkg.sv -----
// Shared types and constants for the 4x4 matrix vertex transform block.
// Holds the word formats of both channels and the queue entry format.
// No dependencies.
`default_nettype none

package m4vt_pkg;

  // Width of every Q-format component on the ports and in the matrix.
  localparam int unsigned CompWidth       = 32;
  // Default number of fraction bits (Q16.16).
  localparam int unsigned FracBitsDefault = 16;
  // Default depth of the queue between front and back.
  localparam int unsigned QueueDepthDefault = 4;

  typedef logic signed [CompWidth-1:0] comp_t;

  // Command codes as they arrive on the input channel.
  typedef enum logic [2:0] {
    CMD_XFORM = 3'd0,
    CMD_WRITE = 3'd1,
    CMD_IDENT = 3'd2,
    CMD_TRANS = 3'd3,
    CMD_SCALE = 3'd4
  } cmd_e;

  // Operations carried through the queue to the back end.
  typedef enum logic [2:0] {
    OP_XFORM,
    OP_WRITE,
    OP_IDENT,
    OP_TRANS,
    OP_SCALE
  } op_e;

  typedef struct packed {
    logic [2:0] cmd;
    logic [1:0] row;
    logic [1:0] col;
    comp_t      entry_value;
    comp_t      in_x;
    comp_t      in_y;
    comp_t      in_z;
    comp_t      in_w;
  } in_word_t;

  typedef struct packed {
    comp_t out_x;
    comp_t out_y;
    comp_t out_z;
    comp_t out_w;
    logic  saturated;
  } out_word_t;

  // One classified operation waiting for the back end.
  typedef struct packed {
    op_e        op;
    logic [3:0] idx;
    comp_t      value;
    comp_t      vx;
    comp_t      vy;
    comp_t      vz;
    comp_t      vw;
  } q_entry_t;

endpackage

`default_nettype wire

// ----- rtl/m4vt_front.sv -----
// Front end: accepts input words and classifies them into queue entries.
// Depends on m4vt_pkg.
`default_nettype none

module m4vt_front (
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire m4vt_pkg::in_word_t in_word_i,
  input  wire logic               q_full_i,
  output logic                    q_push_o,
  output m4vt_pkg::q_entry_t      q_entry_o
);
  import m4vt_pkg::*;

  logic known;

  // Words with an unused command code are accepted and dropped here.
  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && in_ready_o && known;

  always_comb begin
    known        = 1'b1;
    q_entry_o.op = OP_XFORM;
    case (cmd_e'(in_word_i.cmd))
      CMD_XFORM: q_entry_o.op = OP_XFORM;
      CMD_WRITE: q_entry_o.op = OP_WRITE;
      CMD_IDENT: q_entry_o.op = OP_IDENT;
      CMD_TRANS: q_entry_o.op = OP_TRANS;
      CMD_SCALE: q_entry_o.op = OP_SCALE;
      default:   known        = 1'b0;
    endcase
    q_entry_o.idx   = {in_word_i.row, in_word_i.col};
    q_entry_o.value = in_word_i.entry_value;
    q_entry_o.vx    = in_word_i.in_x;
    q_entry_o.vy    = in_word_i.in_y;
    q_entry_o.vz    = in_word_i.in_z;
    q_entry_o.vw    = in_word_i.in_w;
  end

endmodule

`default_nettype wire

// ----- rtl/m4vt_queue.sv -----
// Short FIFO of classified operations between front and back end.
// Depends on m4vt_pkg.
`default_nettype none

module m4vt_queue #(
  parameter int unsigned Depth = m4vt_pkg::QueueDepthDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire m4vt_pkg::q_entry_t entry_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output logic                    valid_o,
  output m4vt_pkg::q_entry_t      entry_o
);
  import m4vt_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  q_entry_t        slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign entry_o = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/m4vt_back.sv -----
// Back end: holds the matrix, applies matrix commands and runs the
// multiply / add / round-and-saturate pipeline. Depends on m4vt_pkg.
`default_nettype none

module m4vt_back #(
  parameter int unsigned FracBits = m4vt_pkg::FracBitsDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                q_valid_i,
  input  wire m4vt_pkg::q_entry_t  q_entry_i,
  output logic                     q_pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output m4vt_pkg::out_word_t      out_word_o
);
  import m4vt_pkg::*;

  localparam int unsigned ProdW = 2 * CompWidth;
  localparam int unsigned PairW = ProdW + 1;
  localparam int unsigned SumW  = ProdW + 2;
  localparam logic [CompWidth-1:0] QOne   = {{(CompWidth-1){1'b0}}, 1'b1} << FracBits;
  localparam logic [CompWidth-1:0] MaxVal = {1'b0, {(CompWidth-1){1'b1}}};
  localparam logic [CompWidth-1:0] MinVal = {1'b1, {(CompWidth-1){1'b0}}};

  logic [CompWidth-1:0]    mat_q [16];
  logic [CompWidth-1:0]    mat_d [16];
  logic signed [ProdW-1:0] prod_q [4][4];
  logic signed [PairW-1:0] pair_q [4][2];
  logic                    vm_q, va_q, out_valid_q;
  out_word_t               out_q, out_d;
  logic                    adv, take, is_xform;
  logic [CompWidth-1:0]    vec [4];
  logic [CompWidth-1:0]    res [4];
  logic [3:0]              clip;

  // The whole pipeline moves when the output register is free or drained.
  assign adv      = !out_valid_q || out_ready_i;
  assign take     = adv && q_valid_i;
  assign q_pop_o  = take;
  assign is_xform = (q_entry_i.op == OP_XFORM);

  assign vec[0] = q_entry_i.vx;
  assign vec[1] = q_entry_i.vy;
  assign vec[2] = q_entry_i.vz;
  assign vec[3] = q_entry_i.vw;

  // Next matrix contents for the command at the queue head.
  always_comb begin
    logic [3:0] k;
    for (int i = 0; i < 16; i++) begin
      k = 4'(i);
      mat_d[i] = mat_q[i];
      if (take) begin
        case (q_entry_i.op)
          OP_WRITE: begin
            if (q_entry_i.idx == k) mat_d[i] = q_entry_i.value;
          end
          OP_IDENT: begin
            mat_d[i] = (k[3:2] == k[1:0]) ? QOne : '0;
          end
          OP_TRANS: begin
            if (k[1:0] == 2'd3 && k[3:2] != 2'd3) begin
              mat_d[i] = vec[k[3:2]];
            end else begin
              mat_d[i] = (k[3:2] == k[1:0]) ? QOne : '0;
            end
          end
          OP_SCALE: begin
            if (k[3:2] != k[1:0]) begin
              mat_d[i] = '0;
            end else if (k[3:2] == 2'd3) begin
              mat_d[i] = QOne;
            end else begin
              mat_d[i] = vec[k[1:0]];
            end
          end
          default: mat_d[i] = mat_q[i];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        mat_q[i] <= ((i / 4) == (i % 4)) ? QOne : '0;
      end
    end else begin
      for (int i = 0; i < 16; i++) begin
        mat_q[i] <= mat_d[i];
      end
    end
  end

  // Round toward minus infinity by dropping fraction bits, then clip.
  always_comb begin
    logic signed [SumW-1:0] total;
    logic signed [SumW-1:0] shifted;
    for (int r = 0; r < 4; r++) begin
      total   = SumW'(pair_q[r][0]) + SumW'(pair_q[r][1]);
      shifted = total >>> FracBits;
      if ((&shifted[SumW-1:CompWidth-1]) || !(|shifted[SumW-1:CompWidth-1])) begin
        res[r]  = shifted[CompWidth-1:0];
        clip[r] = 1'b0;
      end else begin
        res[r]  = shifted[SumW-1] ? MinVal : MaxVal;
        clip[r] = 1'b1;
      end
    end
    out_d.out_x     = res[0];
    out_d.out_y     = res[1];
    out_d.out_z     = res[2];
    out_d.out_w     = res[3];
    out_d.saturated = |clip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q        <= 1'b0;
      va_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vm_q        <= q_valid_i && is_xform;
      va_q        <= vm_q;
      out_valid_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && is_xform) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          prod_q[r][c] <= $signed(mat_q[r*4+c]) * $signed(vec[c]);
        end
      end
    end
    if (adv && vm_q) begin
      for (int r = 0; r < 4; r++) begin
        pair_q[r][0] <= PairW'(prod_q[r][0]) + PairW'(prod_q[r][1]);
        pair_q[r][1] <= PairW'(prod_q[r][2]) + PairW'(prod_q[r][3]);
      end
    end
    if (adv && va_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

// ----- rtl/matrix4_vertex_transform.sv -----
// Path: a transform word passes the queue, multiply, pair add and final add with round
// and saturate registers in turn; matrix commands take effect in queue order.
// Throughput: one word per cycle unless the output stalls, set by the sixteen parallel
// multipliers and output register; the queue absorbs up to QUEUE_DEPTH words in a stall.
// Reset: asynchronous, active low; clears the queue and pipeline and loads identity.
`default_nettype none

module matrix4_vertex_transform #(
  parameter int unsigned FRAC_BITS   = m4vt_pkg::FracBitsDefault,
  parameter int unsigned QUEUE_DEPTH = m4vt_pkg::QueueDepthDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire m4vt_pkg::in_word_t  in_word_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output m4vt_pkg::out_word_t      out_word_o
);
  import m4vt_pkg::*;

  // The front end decodes each input word into an operation and pushes it
  // into the queue. Words with unused command codes are accepted and
  // dropped, so they never reach the matrix or produce a result.
  logic     q_push, q_full, q_pop, q_valid;
  q_entry_t q_in, q_out;

  m4vt_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_in)
  );

  // The queue decouples the input side from the arithmetic pipeline, so
  // new words keep flowing while a finished result waits to be taken.
  m4vt_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_out)
  );

  // The back end owns the matrix. Since commands and transforms leave the
  // queue in order, each transform sees exactly the matrix left by the
  // commands ahead of it.
  m4vt_back #(
    .FracBits (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire
